// ===== hdl/pecm_pkg.sv =====
// Package: shared widths, codes and types of the pointer event coalescing matcher.
package pecm_pkg;

   // Field widths
   localparam int OPCODE_W    = 2;
   localparam int COORD_W     = 16;
   localparam int BTN_W       = 5;
   localparam int MS_W        = 32;
   localparam int TAG_W       = 8;
   localparam int CSR_INDEX_W = 2;

   // Default ring depths
   localparam int EVENT_DEPTH_DEF   = 32;
   localparam int REQUEST_DEPTH_DEF = 32;

   // Item opcodes
   localparam logic [OPCODE_W-1:0] OP_EVENT  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RESIZE = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_X = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_Y = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_Y = 2'd3;

   // Result status codes
   localparam logic STATUS_DELIVER  = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   // One entry of the event ring
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [BTN_W-1:0]          buttons;
      logic [MS_W-1:0]           ms;
   } event_entry_type;

endpackage

// ===== hdl/pecm_if.sv =====
// Interfaces: request and response channels of the pointer event coalescing matcher.
interface pecm_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [pecm_pkg::OPCODE_W-1:0]           opcode;
   logic signed [pecm_pkg::COORD_W-1:0]     pos_x;
   logic signed [pecm_pkg::COORD_W-1:0]     pos_y;
   logic [pecm_pkg::BTN_W-1:0]              button_bits;
   logic [pecm_pkg::MS_W-1:0]               stamp_ms;
   logic [pecm_pkg::TAG_W-1:0]              req_tag;

   modport source (output valid, opcode, pos_x, pos_y, button_bits, stamp_ms, req_tag,
                   input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, button_bits, stamp_ms, req_tag,
                   output ready);
endinterface

interface pecm_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    status;
   logic [pecm_pkg::TAG_W-1:0]              out_tag;
   logic signed [pecm_pkg::COORD_W-1:0]     out_x;
   logic signed [pecm_pkg::COORD_W-1:0]     out_y;
   logic [pecm_pkg::BTN_W-1:0]              out_buttons;
   logic [pecm_pkg::MS_W-1:0]               out_ms;
   logic                                    resized;

   modport source (output valid, status, out_tag, out_x, out_y, out_buttons, out_ms, resized,
                   input ready);
   modport sink   (input valid, status, out_tag, out_x, out_y, out_buttons, out_ms, resized,
                   output ready);
endinterface

// ===== hdl/pecm_clamp.sv =====
// Clamp of an event position to the configured rectangle (maximum wins when inverted).
module pecm_clamp (
   input  logic signed [pecm_pkg::COORD_W-1:0] pos_x,
   input  logic signed [pecm_pkg::COORD_W-1:0] pos_y,
   input  logic signed [pecm_pkg::COORD_W-1:0] min_x,
   input  logic signed [pecm_pkg::COORD_W-1:0] max_x,
   input  logic signed [pecm_pkg::COORD_W-1:0] min_y,
   input  logic signed [pecm_pkg::COORD_W-1:0] max_y,
   output logic signed [pecm_pkg::COORD_W-1:0] clamp_x,
   output logic signed [pecm_pkg::COORD_W-1:0] clamp_y
);

   logic signed [pecm_pkg::COORD_W-1:0] raised_x;
   logic signed [pecm_pkg::COORD_W-1:0] raised_y;

   // raise to the minimum first, then lower to the maximum
   always_comb begin
      raised_x = (pos_x < min_x) ? min_x : pos_x;
      raised_y = (pos_y < min_y) ? min_y : pos_y;
      clamp_x  = (raised_x > max_x) ? max_x : raised_x;
      clamp_y  = (raised_y > max_y) ? max_y : raised_y;
   end

endmodule

// ===== hdl/pointer_event_coalescing_matcher.sv =====
// Top level: pointer event coalescing matcher with event and request rings in memory.
//
// Pairs read requests (tags) with pointer events. Events are clamped to the configured
// rectangle and queued in a ring memory only when their buttons differ from the last queued
// event (or the ring is empty); a full ring stalls and keeps only the newest event until the
// next request. Requests queue in a second ring memory; a request that would fill it comes
// back at once with status 1 and is dropped. An item that pairs a request with an event passes
// through accept and ring write, a synchronous memory read at the ring heads and a load of the
// response register, and the next item is accepted once the response transfer has completed.
// The configuration registers are written through csr_we/csr_index/csr_wdata; the user must
// write them only while the block is idle, which the block itself does not enforce.
module pointer_event_coalescing_matcher #(
   parameter int EVENT_DEPTH   = pecm_pkg::EVENT_DEPTH_DEF,
   parameter int REQUEST_DEPTH = pecm_pkg::REQUEST_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   pecm_req_if.sink                            req_chan,
   pecm_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [pecm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pecm_pkg::COORD_W-1:0]        csr_wdata
);

   localparam int EP_W = $clog2(EVENT_DEPTH);
   localparam int RP_W = $clog2(REQUEST_DEPTH);
   localparam logic [EP_W-1:0] EV_LAST = EP_W'(EVENT_DEPTH - 1);
   localparam logic [RP_W-1:0] RQ_LAST = RP_W'(REQUEST_DEPTH - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DATA = 2'd2;

   // configuration registers
   logic signed [pecm_pkg::COORD_W-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;

   // control state
   logic [1:0]                  state_ff, state_in;
   logic [EP_W-1:0]             ev_rd_ptr_ff, ev_rd_ptr_in;
   logic [EP_W-1:0]             ev_wr_ptr_ff, ev_wr_ptr_in;
   logic [RP_W-1:0]             rq_rd_ptr_ff, rq_rd_ptr_in;
   logic [RP_W-1:0]             rq_wr_ptr_ff, rq_wr_ptr_in;
   logic                        stalled_ff, stalled_in;
   logic [pecm_pkg::BTN_W-1:0]  last_btn_ff, last_btn_in;
   logic                        resize_ff, resize_in;
   logic                        resized_cap_ff, resized_cap_in;

   // memories and read data
   pecm_pkg::event_entry_type   ev_mem [EVENT_DEPTH];
   logic [pecm_pkg::TAG_W-1:0]  rq_mem [REQUEST_DEPTH];
   pecm_pkg::event_entry_type   ev_rdata_ff;
   logic [pecm_pkg::TAG_W-1:0]  rq_rdata_ff;

   // response register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_status_ff, rsp_status_in;
   logic [pecm_pkg::TAG_W-1:0]          rsp_tag_ff, rsp_tag_in;
   pecm_pkg::event_entry_type           rsp_ev_ff, rsp_ev_in;
   logic                                rsp_resized_ff, rsp_resized_in;

   // datapath
   logic                                accept;
   logic signed [pecm_pkg::COORD_W-1:0] clamp_x, clamp_y;
   logic                                ev_we;
   logic [EP_W-1:0]                     ev_waddr;
   pecm_pkg::event_entry_type           ev_wdata;
   logic                                rq_we;
   logic                                rd_en;
   logic [EP_W-1:0]                     ev_wr_next;
   logic [RP_W-1:0]                     rq_wr_next;
   logic                                ev_full;
   logic                                try_match;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   assign ev_wr_next = (ev_wr_ptr_ff == EV_LAST) ? '0 : ev_wr_ptr_ff + EP_W'(1);
   assign rq_wr_next = (rq_wr_ptr_ff == RQ_LAST) ? '0 : rq_wr_ptr_ff + RP_W'(1);
   assign ev_full    = (ev_wr_next == ev_rd_ptr_ff);

   pecm_clamp u_clamp (
      .pos_x   (req_chan.pos_x),
      .pos_y   (req_chan.pos_y),
      .min_x   (min_x_ff),
      .max_x   (max_x_ff),
      .min_y   (min_y_ff),
      .max_y   (max_y_ff),
      .clamp_x (clamp_x),
      .clamp_y (clamp_y)
   );

   assign ev_wdata.x       = clamp_x;
   assign ev_wdata.y       = clamp_y;
   assign ev_wdata.buttons = req_chan.button_bits;
   assign ev_wdata.ms      = req_chan.stamp_ms;

   // item decode, ring updates and match sequencing
   always_comb begin
      state_in       = state_ff;
      ev_rd_ptr_in   = ev_rd_ptr_ff;
      ev_wr_ptr_in   = ev_wr_ptr_ff;
      rq_rd_ptr_in   = rq_rd_ptr_ff;
      rq_wr_ptr_in   = rq_wr_ptr_ff;
      stalled_in     = stalled_ff;
      last_btn_in    = last_btn_ff;
      resize_in      = resize_ff;
      resized_cap_in = resized_cap_ff;
      ev_we          = 1'b0;
      ev_waddr       = ev_wr_ptr_ff;
      rq_we          = 1'b0;
      rd_en          = 1'b0;
      try_match      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_resized_in = rsp_resized_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.opcode)
                  pecm_pkg::OP_EVENT: begin
                     if (!stalled_ff && ((ev_wr_ptr_ff == ev_rd_ptr_ff) ||
                                         (last_btn_ff != req_chan.button_bits))) begin
                        ev_we       = 1'b1;
                        last_btn_in = req_chan.button_bits;
                        try_match   = 1'b1;
                        if (ev_full) begin
                           // ring full: keep only this event, in entry zero
                           ev_waddr     = '0;
                           ev_rd_ptr_in = '0;
                           ev_wr_ptr_in = EP_W'(1);
                           stalled_in   = 1'b1;
                        end else begin
                           ev_wr_ptr_in = ev_wr_next;
                        end
                     end
                  end
                  pecm_pkg::OP_READ: begin
                     if (rq_wr_next == rq_rd_ptr_ff) begin
                        // request ring overflow: answer at once and drop
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = pecm_pkg::STATUS_OVERFLOW;
                        rsp_tag_in     = req_chan.req_tag;
                        rsp_ev_in      = '0;
                        rsp_resized_in = 1'b0;
                     end else begin
                        rq_we        = 1'b1;
                        rq_wr_ptr_in = rq_wr_next;
                        stalled_in   = 1'b0;
                        try_match    = 1'b1;
                     end
                  end
                  pecm_pkg::OP_RESIZE: begin
                     resize_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (try_match && (ev_rd_ptr_in != ev_wr_ptr_in) &&
                   (rq_rd_ptr_in != rq_wr_ptr_in)) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // read both ring heads, advance them, take the resize flag
            rd_en          = 1'b1;
            ev_rd_ptr_in   = (ev_rd_ptr_ff == EV_LAST) ? '0 : ev_rd_ptr_ff + EP_W'(1);
            rq_rd_ptr_in   = (rq_rd_ptr_ff == RQ_LAST) ? '0 : rq_rd_ptr_ff + RP_W'(1);
            resized_cap_in = resize_ff;
            resize_in      = 1'b0;
            state_in       = ST_DATA;
         end
         ST_DATA: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = pecm_pkg::STATUS_DELIVER;
            rsp_tag_in     = rq_rdata_ff;
            rsp_ev_in      = ev_rdata_ff;
            rsp_resized_in = resized_cap_ff;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ev_rd_ptr_ff   <= '0;
         ev_wr_ptr_ff   <= '0;
         rq_rd_ptr_ff   <= '0;
         rq_wr_ptr_ff   <= '0;
         stalled_ff     <= 1'b0;
         last_btn_ff    <= '0;
         resize_ff      <= 1'b0;
         resized_cap_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ev_rd_ptr_ff   <= ev_rd_ptr_in;
         ev_wr_ptr_ff   <= ev_wr_ptr_in;
         rq_rd_ptr_ff   <= rq_rd_ptr_in;
         rq_wr_ptr_ff   <= rq_wr_ptr_in;
         stalled_ff     <= stalled_in;
         last_btn_ff    <= last_btn_in;
         resize_ff      <= resize_in;
         resized_cap_ff <= resized_cap_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_resized_ff <= rsp_resized_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pecm_pkg::CSR_MIN_X: min_x_ff <= csr_wdata;
            pecm_pkg::CSR_MAX_X: max_x_ff <= csr_wdata;
            pecm_pkg::CSR_MIN_Y: min_y_ff <= csr_wdata;
            pecm_pkg::CSR_MAX_Y: max_y_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // event ring memory
   always_ff @(posedge clock) begin
      if (ev_we) begin
         ev_mem[ev_waddr] <= ev_wdata;
      end
      if (rd_en) begin
         ev_rdata_ff <= ev_mem[ev_rd_ptr_ff];
      end
   end

   // request ring memory
   always_ff @(posedge clock) begin
      if (rq_we) begin
         rq_mem[rq_wr_ptr_ff] <= req_chan.req_tag;
      end
      if (rd_en) begin
         rq_rdata_ff <= rq_mem[rq_rd_ptr_ff];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.out_tag     = rsp_tag_ff;
   assign rsp_chan.out_x       = rsp_ev_ff.x;
   assign rsp_chan.out_y       = rsp_ev_ff.y;
   assign rsp_chan.out_buttons = rsp_ev_ff.buttons;
   assign rsp_chan.out_ms      = rsp_ev_ff.ms;
   assign rsp_chan.resized     = rsp_resized_ff;

endmodule

// ===== dv/pointer_event_coalescing_matcher_test.sv =====
// Testbench: pointer event coalescing matcher, checked against an in-bench behavioral predictor.
module pointer_event_coalescing_matcher_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Opcode the block must ignore
   localparam logic [pecm_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   // Cycles to let the block finish an item that produces no result
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int PRINT_LIMIT   = 100;

   typedef struct packed {
      logic [pecm_pkg::OPCODE_W-1:0]       op;
      logic signed [pecm_pkg::COORD_W-1:0] x;
      logic signed [pecm_pkg::COORD_W-1:0] y;
      logic [pecm_pkg::BTN_W-1:0]          buttons;
      logic [pecm_pkg::MS_W-1:0]           ms;
      logic [pecm_pkg::TAG_W-1:0]          tag;
   } pointer_cmd_type;

   typedef struct packed {
      logic                                status;
      logic [pecm_pkg::TAG_W-1:0]          tag;
      logic signed [pecm_pkg::COORD_W-1:0] x;
      logic signed [pecm_pkg::COORD_W-1:0] y;
      logic [pecm_pkg::BTN_W-1:0]          buttons;
      logic [pecm_pkg::MS_W-1:0]           ms;
      logic                                resized;
   } pointer_report_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we;
   logic [pecm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pecm_pkg::COORD_W-1:0]     csr_wdata;

   pecm_req_if req_chan ();
   pecm_rsp_if rsp_chan ();

   pointer_event_coalescing_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: clamping rectangle, event and tag rings, flags
   logic signed [pecm_pkg::COORD_W-1:0] clip_min_x = '0;
   logic signed [pecm_pkg::COORD_W-1:0] clip_max_x = '0;
   logic signed [pecm_pkg::COORD_W-1:0] clip_min_y = '0;
   logic signed [pecm_pkg::COORD_W-1:0] clip_max_y = '0;
   pecm_pkg::event_entry_type           motion_ring [pecm_pkg::EVENT_DEPTH_DEF];
   logic [pecm_pkg::TAG_W-1:0]          tag_ring [pecm_pkg::REQUEST_DEPTH_DEF];
   int unsigned                         motion_head = 0;
   int unsigned                         motion_tail = 0;
   int unsigned                         tag_head = 0;
   int unsigned                         tag_tail = 0;
   logic                                motion_stalled = 1'b0;
   logic [pecm_pkg::BTN_W-1:0]          last_buttons = '0;
   logic                                resize_seen = 1'b0;

   pointer_report_type expected_reports [$];
   int                 mismatch_count = 0;
   bit                 idle_enabled = 1'b1;

   // Clock
   initial begin
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   function automatic int unsigned ring_next(input int unsigned p, input int unsigned depth);
      return (p + 1 >= depth) ? 0 : p + 1;
   endfunction

   // Raise to the minimum first, then lower to the maximum
   function automatic logic signed [pecm_pkg::COORD_W-1:0] clip(
         input logic signed [pecm_pkg::COORD_W-1:0] v, lo, hi);
      logic signed [pecm_pkg::COORD_W-1:0] r;
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   // Pair the oldest request with the oldest event when both rings hold one
   function automatic void pair_heads();
      pointer_report_type r;
      if (motion_head == motion_tail || tag_head == tag_tail) return;
      r.status  = pecm_pkg::STATUS_DELIVER;
      r.tag     = tag_ring[tag_head];
      r.x       = motion_ring[motion_head].x;
      r.y       = motion_ring[motion_head].y;
      r.buttons = motion_ring[motion_head].buttons;
      r.ms      = motion_ring[motion_head].ms;
      r.resized = resize_seen;
      resize_seen = 1'b0;
      tag_head    = ring_next(tag_head, pecm_pkg::REQUEST_DEPTH_DEF);
      motion_head = ring_next(motion_head, pecm_pkg::EVENT_DEPTH_DEF);
      expected_reports.push_back(r);
   endfunction

   // Expected effect of one accepted item
   function automatic void predict_item(input pointer_cmd_type c);
      pecm_pkg::event_entry_type e;
      pointer_report_type        r;
      e.x       = clip(c.x, clip_min_x, clip_max_x);
      e.y       = clip(c.y, clip_min_y, clip_max_y);
      e.buttons = c.buttons;
      e.ms      = c.ms;
      case (c.op)
         pecm_pkg::OP_EVENT: begin
            // coalesce: drop while stalled or when buttons repeat on a non-empty ring
            if (!motion_stalled &&
                (motion_head == motion_tail || last_buttons != c.buttons)) begin
               last_buttons = c.buttons;
               motion_ring[motion_tail] = e;
               motion_tail = ring_next(motion_tail, pecm_pkg::EVENT_DEPTH_DEF);
               if (motion_tail == motion_head) begin
                  // ring full: stall and keep only the newest event
                  motion_stalled = 1'b1;
                  motion_head    = 0;
                  motion_tail    = 1;
                  motion_ring[0] = e;
               end
               pair_heads();
            end
         end
         pecm_pkg::OP_READ: begin
            if (ring_next(tag_tail, pecm_pkg::REQUEST_DEPTH_DEF) == tag_head) begin
               r = '0;
               r.status = pecm_pkg::STATUS_OVERFLOW;
               r.tag    = c.tag;
               expected_reports.push_back(r);
            end else begin
               tag_ring[tag_tail] = c.tag;
               tag_tail = ring_next(tag_tail, pecm_pkg::REQUEST_DEPTH_DEF);
               motion_stalled = 1'b0;
               pair_heads();
            end
         end
         pecm_pkg::OP_RESIZE: begin
            resize_seen = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // Item builders; fields the opcode ignores carry random values
   function automatic pointer_cmd_type random_cmd(input logic [pecm_pkg::OPCODE_W-1:0] op);
      pointer_cmd_type c;
      c.op      = op;
      c.x       = pecm_pkg::COORD_W'($urandom);
      c.y       = pecm_pkg::COORD_W'($urandom);
      c.buttons = pecm_pkg::BTN_W'($urandom);
      c.ms      = $urandom;
      c.tag     = pecm_pkg::TAG_W'($urandom);
      return c;
   endfunction

   function automatic pointer_cmd_type event_cmd(
         input logic signed [pecm_pkg::COORD_W-1:0] x, y,
         input logic [pecm_pkg::BTN_W-1:0] b,
         input logic [pecm_pkg::MS_W-1:0] ms);
      pointer_cmd_type c;
      c = random_cmd(pecm_pkg::OP_EVENT);
      c.x       = x;
      c.y       = y;
      c.buttons = b;
      c.ms      = ms;
      return c;
   endfunction

   function automatic pointer_cmd_type read_cmd(input logic [pecm_pkg::TAG_W-1:0] tag);
      pointer_cmd_type c;
      c = random_cmd(pecm_pkg::OP_READ);
      c.tag = tag;
      return c;
   endfunction

   // Coordinate with extra weight on the extremes and on small values
   function automatic logic signed [pecm_pkg::COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
         default: return pecm_pkg::COORD_W'($urandom);
      endcase
   endfunction

   // Drive one item and wait for its transfer
   task automatic send_item(input pointer_cmd_type c);
      @(negedge clock);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_chan.opcode      = c.op;
      req_chan.pos_x       = c.x;
      req_chan.pos_y       = c.y;
      req_chan.button_bits = c.buttons;
      req_chan.stamp_ms    = c.ms;
      req_chan.req_tag     = c.tag;
      req_chan.valid       = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      predict_item(c);
   endtask

   // Stop sending and wait until every expected result has come back
   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0) begin
         report_mismatch("results never delivered, count", 64'd0,
                         64'(expected_reports.size()));
         expected_reports.delete();
      end
   endtask

   task automatic write_csr(input logic [pecm_pkg::CSR_INDEX_W-1:0] index,
                            input logic signed [pecm_pkg::COORD_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      case (index)
         pecm_pkg::CSR_MIN_X: clip_min_x = value;
         pecm_pkg::CSR_MAX_X: clip_max_x = value;
         pecm_pkg::CSR_MIN_Y: clip_min_y = value;
         pecm_pkg::CSR_MAX_Y: clip_max_y = value;
         default: ;
      endcase
   endtask

   // New clamping rectangle, written only once the block is idle
   task automatic write_rect(input logic signed [pecm_pkg::COORD_W-1:0] x0, x1, y0, y1);
      settle();
      write_csr(pecm_pkg::CSR_MIN_X, x0);
      write_csr(pecm_pkg::CSR_MAX_X, x1);
      write_csr(pecm_pkg::CSR_MIN_Y, y0);
      write_csr(pecm_pkg::CSR_MAX_Y, y1);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_random_rect(input bit inverted);
      logic signed [pecm_pkg::COORD_W-1:0] ax, bx, ay, by, lo_x, hi_x, lo_y, hi_y;
      ax = pick_coord();
      bx = pick_coord();
      ay = pick_coord();
      by = pick_coord();
      lo_x = (ax < bx) ? ax : bx;
      hi_x = (ax < bx) ? bx : ax;
      lo_y = (ay < by) ? ay : by;
      hi_y = (ay < by) ? by : ay;
      if (inverted)
         write_rect(hi_x, lo_x, hi_y, lo_y);
      else
         write_rect(lo_x, hi_x, lo_y, hi_y);
   endtask

   // Pairing order, button coalescing, resize flag, extremes of every field
   task automatic test_basic_pairing();
      write_rect(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_item(random_cmd(pecm_pkg::OP_RESIZE));
      send_item(event_cmd(16'sh8000, 16'sh7FFF, 5'd0, 32'd0));
      send_item(event_cmd(16'sd100, -16'sd100, 5'd0, 32'd1));
      send_item(event_cmd(16'sh7FFF, 16'sh8000, 5'h1F, 32'hFFFF_FFFF));
      send_item(read_cmd(8'h00));
      send_item(read_cmd(8'hFF));
      send_item(read_cmd(8'h5A));
      send_item(event_cmd(16'sd0, 16'sd0, 5'h1F, 32'h5555_AAAA));
      send_item(random_cmd(OP_UNUSED));
      send_item(random_cmd(pecm_pkg::OP_RESIZE));
      send_item(read_cmd(8'hA5));
      send_item(event_cmd(16'sd1, -16'sd1, 5'h15, 32'hAAAA_5555));
   endtask

   // Clamping to a normal, an inverted and a degenerate rectangle
   task automatic test_clamping();
      write_rect(-16'sd100, 16'sd100, -16'sd50, 16'sd50);
      send_item(event_cmd(16'sh8000, 16'sh7FFF, 5'd1, $urandom));
      send_item(event_cmd(16'sh7FFF, 16'sh8000, 5'd2, $urandom));
      send_item(event_cmd(16'sd7, -16'sd7, 5'd3, $urandom));
      send_item(read_cmd(pecm_pkg::TAG_W'($urandom)));
      send_item(read_cmd(pecm_pkg::TAG_W'($urandom)));
      send_item(read_cmd(pecm_pkg::TAG_W'($urandom)));
      write_rect(16'sd100, -16'sd100, 16'sd50, -16'sd50);
      send_item(event_cmd(16'sd0, 16'sd0, 5'd4, $urandom));
      send_item(event_cmd(16'sh8000, 16'sh7FFF, 5'd5, $urandom));
      send_item(read_cmd(pecm_pkg::TAG_W'($urandom)));
      send_item(read_cmd(pecm_pkg::TAG_W'($urandom)));
      write_rect(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
      send_item(event_cmd(16'sd0, 16'sd0, 5'd6, $urandom));
      send_item(read_cmd(pecm_pkg::TAG_W'($urandom)));
   endtask

   // Fill the request ring until requests are dropped, then serve the queued ones
   task automatic test_request_overflow();
      write_rect(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      for (int i = 0; i < pecm_pkg::REQUEST_DEPTH_DEF + 1; i++)
         send_item(read_cmd(8'(i)));
      send_item(random_cmd(pecm_pkg::OP_RESIZE));
      for (int i = 0; i < pecm_pkg::REQUEST_DEPTH_DEF - 1; i++)
         send_item(event_cmd(pick_coord(), pick_coord(), 5'(i), $urandom));
   endtask

   // Fill the event ring until it stalls, discard while stalled, then release
   task automatic test_event_stall();
      for (int i = 0; i < pecm_pkg::EVENT_DEPTH_DEF; i++)
         send_item(event_cmd(pick_coord(), pick_coord(), 5'(i), $urandom));
      for (int i = 0; i < 4; i++)
         send_item(event_cmd(pick_coord(), pick_coord(), pecm_pkg::BTN_W'($urandom),
                             $urandom));
      send_item(read_cmd(pecm_pkg::TAG_W'($urandom)));
      send_item(event_cmd(pick_coord(), pick_coord(), 5'h1F, $urandom));
      send_item(read_cmd(pecm_pkg::TAG_W'($urandom)));
      send_item(read_cmd(pecm_pkg::TAG_W'($urandom)));
      send_item(event_cmd(pick_coord(), pick_coord(), 5'h1F, $urandom));
   endtask

   // Bursts of events and requests, with some long enough to stall or overflow
   task automatic test_random_traffic(input int items);
      int                         sent;
      int                         kind;
      int                         burst;
      logic [pecm_pkg::BTN_W-1:0] btn;
      sent = 0;
      btn  = pecm_pkg::BTN_W'($urandom);
      while (sent < items) begin
         kind  = $urandom_range(0, 19);
         burst = (kind == 0 || kind == 9) ? $urandom_range(28, 40) : $urandom_range(1, 10);
         if (kind < 9) begin
            for (int i = 0; i < burst; i++) begin
               if (kind == 0 || $urandom_range(0, 3) != 0)
                  btn = btn + 5'($urandom_range(1, 31));
               send_item(event_cmd(pick_coord(), pick_coord(), btn, $urandom));
            end
            sent += burst;
         end else if (kind < 17) begin
            for (int i = 0; i < burst; i++)
               send_item(read_cmd(pecm_pkg::TAG_W'($urandom)));
            sent += burst;
         end else if (kind < 19) begin
            send_item(random_cmd(pecm_pkg::OP_RESIZE));
            sent++;
         end else begin
            send_item(random_cmd(OP_UNUSED));
         end
      end
   endtask

   // Result side: random stall bursts
   initial begin
      rsp_chan.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_enabled && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      pointer_report_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("result with nothing expected, tag", 64'(rsp_chan.out_tag),
                            64'd0);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", 64'(rsp_chan.status), 64'(want.status));
            if (rsp_chan.out_tag !== want.tag)
               report_mismatch("out_tag", 64'(rsp_chan.out_tag), 64'(want.tag));
            if (rsp_chan.out_x !== want.x)
               report_mismatch("out_x", 64'($unsigned(rsp_chan.out_x)),
                               64'($unsigned(want.x)));
            if (rsp_chan.out_y !== want.y)
               report_mismatch("out_y", 64'($unsigned(rsp_chan.out_y)),
                               64'($unsigned(want.y)));
            if (rsp_chan.out_buttons !== want.buttons)
               report_mismatch("out_buttons", 64'(rsp_chan.out_buttons), 64'(want.buttons));
            if (rsp_chan.out_ms !== want.ms)
               report_mismatch("out_ms", 64'(rsp_chan.out_ms), 64'(want.ms));
            if (rsp_chan.resized !== want.resized)
               report_mismatch("resized", 64'(rsp_chan.resized), 64'(want.resized));
         end
      end
   end

   // Test sequence
   initial begin
      req_chan.valid       = 1'b0;
      req_chan.opcode      = pecm_pkg::OP_EVENT;
      req_chan.pos_x       = '0;
      req_chan.pos_y       = '0;
      req_chan.button_bits = '0;
      req_chan.stamp_ms    = '0;
      req_chan.req_tag     = '0;
      csr_we               = 1'b0;
      csr_index            = pecm_pkg::CSR_MIN_X;
      csr_wdata            = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_pairing();
      test_clamping();
      test_request_overflow();
      test_event_stall();

      write_rect(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      test_random_traffic(220);
      write_random_rect(1'b0);
      test_random_traffic(220);
      write_random_rect(1'b1);
      test_random_traffic(220);
      write_rect(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
      test_random_traffic(220);
      write_random_rect(1'b0);
      idle_enabled = 1'b0;
      test_random_traffic(220);
      settle();

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== pointer_event_coalescing_matcher.f =====
hdl/pecm_pkg.sv
hdl/pecm_if.sv
hdl/pecm_clamp.sv
hdl/pointer_event_coalescing_matcher.sv
dv/pointer_event_coalescing_matcher_test.sv
